// ===== rtl/core/trace_parent_header_parser_unit_assert.svh =====
// Assertion macros for the traceparent parser
`ifndef TRACE_PARENT_HEADER_PARSER_UNIT_ASSERT_SVH
`define TRACE_PARENT_HEADER_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TPP_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tpp: implication check failed");
`define TPP_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tpp: next-cycle check failed");
`else
`define TPP_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define TPP_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/core/tpp_pkg.sv =====
`default_nettype none
package tpp_pkg;

    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [3:0] ALPHA_OFFSET = 4'd9;

    localparam logic [5:0] HDR_LEN = 6'd55;
    localparam logic [5:0] LEN_SAT = 6'd56;
    localparam logic [2:0] PIECE_SAT = 3'd7;
    localparam logic [2:0] PIECE_NUM = 3'd4;

    localparam logic [5:0] DASH_A = 6'd2;
    localparam logic [5:0] DASH_B = 6'd35;
    localparam logic [5:0] DASH_C = 6'd52;

    localparam logic [5:0] TRACE_HI_FIRST = 6'd3;
    localparam logic [5:0] TRACE_HI_LAST  = 6'd18;
    localparam logic [5:0] TRACE_LO_FIRST = 6'd19;
    localparam logic [5:0] TRACE_LO_LAST  = 6'd34;
    localparam logic [5:0] SPAN_FIRST     = 6'd36;
    localparam logic [5:0] SPAN_LAST      = 6'd51;
    localparam logic [5:0] FLAGS_FIRST    = 6'd53;
    localparam logic [5:0] FLAGS_LAST     = 6'd54;

    typedef enum logic [2:0] {
        ST_OK,
        ST_LENGTH,
        ST_PIECES,
        ST_LAYOUT,
        ST_HEX,
        ST_ZERO_TRACE,
        ST_ZERO_SPAN
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  version;
        logic [63:0] trace_id_high;
        logic [63:0] trace_id_low;
        logic [63:0] span_id;
        logic        sampled;
    } t_result;

    // {valid, nibble}; a non-hex byte decodes as zero
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
            r = {1'b1, c[3:0] + ALPHA_OFFSET};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/trace_parent_header_parser_unit.sv =====
// Traceparent header parser.
// Input channel: one header character per transaction (i_char_byte), with
// i_last_byte set on the final character. Output channel: one transaction per
// header, carrying status and the decoded version, trace id, span id and
// sampled flag; every field but status reads zero when status is not ok.
// Both channels use valid/stall; a transaction completes when valid is high
// and stall is low.
// Throughput: one character per cycle while o_stall is low. The per-character
// update of the parse state is the single combinational step between the
// input register and the result register.
// A result is valid once its final character has passed the input and result
// registers. Characters that are not final give no result.
// Reset (synchronous, active low) clears both valid flags and returns the
// parse state to the start of a header; after each final character the state
// returns there too. While the receiver stalls a waiting result, further
// characters are still taken; only a second final character stalls the input.
`default_nettype none
module trace_parent_header_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [7:0]       o_version,
    output logic [63:0]      o_trace_id_high,
    output logic [63:0]      o_trace_id_low,
    output logic [63:0]      o_span_id,
    output logic             o_sampled
);
    import tpp_pkg::*;

    logic       r_s1_valid;
    logic [7:0] r_s1_char;
    logic       r_s1_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_result;
    logic       adv;
    logic       step;

    assign adv  = !(r_s1_valid && r_s1_last && r_out_valid && i_stall);
    assign step = r_s1_valid && adv;

    assign o_stall = !adv;

    tpp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_char_byte (r_s1_char),
        .i_last_byte (r_s1_last),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_s1_char <= i_char_byte;
            r_s1_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_s1_last) begin
            r_out <= core_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_version       = r_out.version;
    assign o_trace_id_high = r_out.trace_id_high;
    assign o_trace_id_low  = r_out.trace_id_low;
    assign o_span_id       = r_out.span_id;
    assign o_sampled       = r_out.sampled;

`include "trace_parent_header_parser_unit_assert.svh"

    `TPP_ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK, o_version == 8'd0 && o_trace_id_high == 64'd0 && o_span_id == 64'd0 && !o_sampled)
    `TPP_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_stall, r_s1_valid && r_s1_last && r_out_valid)
    `TPP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, step && r_s1_last, r_out_valid)
    `TPP_ASSERT_IMPLY(a_status_range, i_clk, i_rst_n, o_valid, o_status <= ST_ZERO_SPAN)

endmodule
`default_nettype wire

// ===== rtl/core/tpp_parse_core.sv =====
`default_nettype none
module tpp_parse_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic [7:0]     i_char_byte,
    input  wire logic           i_last_byte,
    output tpp_pkg::t_result    o_result
);
    import tpp_pkg::*;

    logic [5:0]  r_char_count, n_char_count;
    logic [2:0]  r_piece_count, n_piece_count;
    logic        r_prev_dash, n_prev_dash;
    logic        r_dash_ok, n_dash_ok;
    logic        r_hex_ok, n_hex_ok;
    logic        r_trace_nz, n_trace_nz;
    logic        r_span_nz, n_span_nz;
    logic [7:0]  r_version, n_version;
    logic [63:0] r_trace_hi, n_trace_hi;
    logic [63:0] r_trace_lo, n_trace_lo;
    logic [63:0] r_span, n_span;
    logic [7:0]  r_flags, n_flags;

    logic [4:0]  hx;
    logic [3:0]  nib;
    logic        is_dash;
    logic [5:0]  pos;
    t_status     status;

    always_comb begin
        hx      = hex_decode(i_char_byte);
        nib     = hx[3:0];
        is_dash = (i_char_byte == CH_DASH);
        pos     = r_char_count;

        n_char_count  = r_char_count;
        n_piece_count = r_piece_count;
        n_dash_ok     = r_dash_ok;
        n_hex_ok      = r_hex_ok;
        n_trace_nz    = r_trace_nz;
        n_span_nz     = r_span_nz;
        n_version     = r_version;
        n_trace_hi    = r_trace_hi;
        n_trace_lo    = r_trace_lo;
        n_span        = r_span;
        n_flags       = r_flags;

        if (is_dash) begin
            if (pos != DASH_A && pos != DASH_B && pos != DASH_C) begin
                n_dash_ok = 1'b0;
            end
        end else begin
            if (!hx[4]) begin
                n_hex_ok = 1'b0;
            end
            if (r_prev_dash && r_piece_count < PIECE_SAT) begin
                n_piece_count = r_piece_count + 3'd1;
            end
            if (pos < DASH_A) begin
                n_version = {r_version[3:0], nib};
            end else if (pos >= TRACE_HI_FIRST && pos <= TRACE_HI_LAST) begin
                n_trace_hi = {r_trace_hi[59:0], nib};
                if (nib != 4'd0) n_trace_nz = 1'b1;
            end else if (pos >= TRACE_LO_FIRST && pos <= TRACE_LO_LAST) begin
                n_trace_lo = {r_trace_lo[59:0], nib};
                if (nib != 4'd0) n_trace_nz = 1'b1;
            end else if (pos >= SPAN_FIRST && pos <= SPAN_LAST) begin
                n_span = {r_span[59:0], nib};
                if (nib != 4'd0) n_span_nz = 1'b1;
            end else if (pos >= FLAGS_FIRST && pos <= FLAGS_LAST) begin
                n_flags = {r_flags[3:0], nib};
            end
        end
        n_prev_dash = is_dash;
        if (r_char_count < LEN_SAT) begin
            n_char_count = r_char_count + 6'd1;
        end

        if (n_char_count != HDR_LEN)        status = ST_LENGTH;
        else if (n_piece_count != PIECE_NUM) status = ST_PIECES;
        else if (!n_dash_ok)                 status = ST_LAYOUT;
        else if (!n_hex_ok)                  status = ST_HEX;
        else if (!n_trace_nz)                status = ST_ZERO_TRACE;
        else if (!n_span_nz)                 status = ST_ZERO_SPAN;
        else                                 status = ST_OK;

        o_result = '0;
        o_result.status = status;
        if (status == ST_OK) begin
            o_result.version       = n_version;
            o_result.trace_id_high = n_trace_hi;
            o_result.trace_id_low  = n_trace_lo;
            o_result.span_id       = n_span;
            o_result.sampled       = n_flags[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_char_count  <= '0;
            r_piece_count <= '0;
            r_prev_dash   <= 1'b1;
            r_dash_ok     <= 1'b1;
            r_hex_ok      <= 1'b1;
            r_trace_nz    <= 1'b0;
            r_span_nz     <= 1'b0;
            r_version     <= '0;
            r_trace_hi    <= '0;
            r_trace_lo    <= '0;
            r_span        <= '0;
            r_flags       <= '0;
        end else if (i_step) begin
            r_char_count  <= n_char_count;
            r_piece_count <= n_piece_count;
            r_prev_dash   <= n_prev_dash;
            r_dash_ok     <= n_dash_ok;
            r_hex_ok      <= n_hex_ok;
            r_trace_nz    <= n_trace_nz;
            r_span_nz     <= n_span_nz;
            r_version     <= n_version;
            r_trace_hi    <= n_trace_hi;
            r_trace_lo    <= n_trace_lo;
            r_span        <= n_span;
            r_flags       <= n_flags;
        end
    end

endmodule
`default_nettype wire
